FILE: src/segint_pkg.sv
`default_nettype none
package segint_pkg;

	// coordinate width and derived datapath widths
	localparam int W  = 16;
	localparam int CW = 2 * W + 1;      // c1, c2
	localparam int DW = 2 * W + 3;      // determinant
	localparam int NW = 3 * W + 3;      // numerators
	localparam int QB = W + 2;          // quotient bits kept by the divider
	localparam int EW = W + 3;          // signed width of the point for box tests

	localparam int DET_TOL_W   = 16;
	localparam int COORD_TOL_W = 8;
	localparam int CFG_W       = 16;

	// register indexes
	localparam logic REG_DET_TOL   = 1'b0;
	localparam logic REG_COORD_TOL = 1'b1;

	// status codes
	localparam logic [1:0] ST_PARALLEL = 2'd0;
	localparam logic [1:0] ST_OUTSIDE  = 2'd1;
	localparam logic [1:0] ST_ENDPOINT = 2'd2;
	localparam logic [1:0] ST_HIT      = 2'd3;

	typedef struct packed {
		logic signed [W-1:0] x1;
		logic signed [W-1:0] y1;
		logic signed [W-1:0] x2;
		logic signed [W-1:0] y2;
		logic signed [W-1:0] x3;
		logic signed [W-1:0] y3;
		logic signed [W-1:0] x4;
		logic signed [W-1:0] y4;
	} coords_t;

	typedef struct packed {
		logic    par;
		coords_t c;
	} side_t;

endpackage
`default_nettype wire

FILE: src/segint_in_if.sv
`default_nettype none
interface segint_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [segint_pkg::W-1:0] a_start_x;
	logic signed [segint_pkg::W-1:0] a_start_y;
	logic signed [segint_pkg::W-1:0] a_end_x;
	logic signed [segint_pkg::W-1:0] a_end_y;
	logic signed [segint_pkg::W-1:0] b_start_x;
	logic signed [segint_pkg::W-1:0] b_start_y;
	logic signed [segint_pkg::W-1:0] b_end_x;
	logic signed [segint_pkg::W-1:0] b_end_y;

	modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
		b_start_x, b_start_y, b_end_x, b_end_y, input ready);
	modport sink (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
		b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface
`default_nettype wire

FILE: src/segint_out_if.sv
`default_nettype none
interface segint_out_if;
	logic                                 valid;
	logic                                 ready;
	logic [1:0]                           status;
	logic signed [segint_pkg::W-1:0] cross_x;
	logic signed [segint_pkg::W-1:0] cross_y;

	modport source (output valid, status, cross_x, cross_y, input ready);
	modport sink (input valid, status, cross_x, cross_y, output ready);
endinterface
`default_nettype wire

FILE: src/segint_div.sv
`default_nettype none
module segint_div (
	input  wire logic                                clk,
	input  wire logic                                ce,
	input  wire logic signed [segint_pkg::NW-1:0] num,
	input  wire logic        [segint_pkg::DW-1:0] den_mag,
	input  wire logic                                den_neg,
	output logic             [segint_pkg::QB-1:0] q_mag,
	output logic                                     q_neg,
	output logic                                     big
);
	localparam int NW = segint_pkg::NW;
	localparam int DW = segint_pkg::DW;
	localparam int QB = segint_pkg::QB;

	logic [DW-1:0] rem_s [QB+1];
	logic [QB-1:0] lo_s  [QB+1];
	logic [QB-1:0] q_s   [QB+1];
	logic [DW-1:0] md_s  [QB+1];
	logic          neg_s [QB+1];
	logic          big_s [QB+1];

	logic [NW-1:0]    mn;
	logic [NW-QB-1:0] r0;

	// take magnitudes; a quotient of 2^QB or more only needs the flag
	assign mn = num[NW-1] ? NW'(-num) : NW'(num);
	assign r0 = mn[NW-1:QB];

	always_ff @(posedge clk) begin
		if (ce) begin
			rem_s[0] <= DW'(r0);
			lo_s[0]  <= mn[QB-1:0];
			q_s[0]   <= '0;
			md_s[0]  <= den_mag;
			neg_s[0] <= num[NW-1] ^ den_neg;
			big_s[0] <= {{(DW-(NW-QB)){1'b0}}, r0} >= den_mag;
		end
	end

	// one restoring step per stage
	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [DW:0] rr;
		logic        ge;
		assign rr = {rem_s[k], lo_s[k][QB-1]};
		assign ge = rr >= {1'b0, md_s[k]};
		always_ff @(posedge clk) begin
			if (ce) begin
				rem_s[k+1] <= ge ? DW'(rr - {1'b0, md_s[k]}) : rr[DW-1:0];
				lo_s[k+1]  <= {lo_s[k][QB-2:0], 1'b0};
				q_s[k+1]   <= {q_s[k][QB-2:0], ge};
				md_s[k+1]  <= md_s[k];
				neg_s[k+1] <= neg_s[k];
				big_s[k+1] <= big_s[k];
			end
		end
	end

	assign q_mag = q_s[QB];
	assign q_neg = neg_s[QB];
	assign big   = big_s[QB];
endmodule
`default_nettype wire

FILE: src/segment_intersection.sv
// Channel   Modport  Payload
// in_seg    sink     a_start_x/y, a_end_x/y, b_start_x/y, b_end_x/y (signed Q11.4)
// out_res   source   status, cross_x, cross_y
// cfg       write    cfg_we, cfg_index, cfg_data
//
// One request per cycle while the output is not stalled. The pipeline has three
// multiply/subtract stages, one subtract and magnitude stage, a restoring
// divider of QB + 1 stages (range check, then one quotient bit per stage),
// plus the output register.
// Reset clears valid bits and sets both tolerances to 1.
// A stall at the output freezes the whole pipeline; nothing is dropped.
`default_nettype none
module segment_intersection (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic                              cfg_index,
	input  wire logic [segint_pkg::CFG_W-1:0]   cfg_data,
	segint_in_if.sink                              in_seg,
	segint_out_if.source                           out_res
);
	localparam int W  = segint_pkg::W;
	localparam int CW = segint_pkg::CW;
	localparam int DW = segint_pkg::DW;
	localparam int NW = segint_pkg::NW;
	localparam int QB = segint_pkg::QB;
	localparam int EW = segint_pkg::EW;

	logic [segint_pkg::DET_TOL_W-1:0]   det_tol_q;
	logic [segint_pkg::COORD_TOL_W-1:0] coord_tol_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_tol_q   <= segint_pkg::DET_TOL_W'(1);
			coord_tol_q <= segint_pkg::COORD_TOL_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				segint_pkg::REG_DET_TOL:   det_tol_q <= cfg_data[segint_pkg::DET_TOL_W-1:0];
				segint_pkg::REG_COORD_TOL: coord_tol_q <= cfg_data[segint_pkg::COORD_TOL_W-1:0];
				default: ;
			endcase
		end
	end

	logic out_v_q;
	logic ce;
	assign ce = !out_v_q || out_res.ready;
	assign in_seg.ready = ce;

	segint_pkg::coords_t cin;
	assign cin = '{in_seg.a_start_x, in_seg.a_start_y, in_seg.a_end_x, in_seg.a_end_y,
		in_seg.b_start_x, in_seg.b_start_y, in_seg.b_end_x, in_seg.b_end_y};

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4;
	logic vd_s [QB+1];

	// stage 1: differences and cross products of the endpoints
	segint_pkg::coords_t c_s1, c_s2, c_s3, c_s4;
	logic signed [W:0]     d1x_s1, d1y_s1, d2x_s1, d2y_s1;
	logic signed [2*W-1:0] p1_s1, p2_s1, p3_s1, p4_s1;
	// stage 2
	logic signed [W:0]     d1x_s2, d1y_s2, d2x_s2, d2y_s2;
	logic signed [CW-1:0]  c1_s2, c2_s2;
	logic signed [2*W+1:0] m1_s2, m2_s2;
	// stage 3
	logic signed [DW-1:0]   det_s3;
	logic signed [NW-2:0]   n1_s3, n2_s3, n3_s3, n4_s3;
	// stage 4
	logic signed [NW-1:0]  nx_s4, ny_s4;
	logic        [DW-1:0]  adet_s4;
	logic                  dneg_s4;
	logic                  par_s4;

	logic [DW-1:0] adet_c;
	assign adet_c = det_s3[DW-1] ? DW'(-det_s3) : DW'(det_s3);

	always_ff @(posedge clk) begin
		if (ce) begin
			c_s1   <= cin;
			d1x_s1 <= (W+1)'(cin.x1) - (W+1)'(cin.x2);
			d1y_s1 <= (W+1)'(cin.y1) - (W+1)'(cin.y2);
			d2x_s1 <= (W+1)'(cin.x3) - (W+1)'(cin.x4);
			d2y_s1 <= (W+1)'(cin.y3) - (W+1)'(cin.y4);
			p1_s1  <= cin.x1 * cin.y2;
			p2_s1  <= cin.y1 * cin.x2;
			p3_s1  <= cin.x3 * cin.y4;
			p4_s1  <= cin.y3 * cin.x4;

			c_s2   <= c_s1;
			d1x_s2 <= d1x_s1;
			d1y_s2 <= d1y_s1;
			d2x_s2 <= d2x_s1;
			d2y_s2 <= d2y_s1;
			c1_s2  <= CW'(p1_s1) - CW'(p2_s1);
			c2_s2  <= CW'(p3_s1) - CW'(p4_s1);
			m1_s2  <= d1x_s1 * d2y_s1;
			m2_s2  <= d1y_s1 * d2x_s1;

			c_s3   <= c_s2;
			det_s3 <= DW'(m1_s2) - DW'(m2_s2);
			n1_s3  <= c1_s2 * d2x_s2;
			n2_s3  <= c2_s2 * d1x_s2;
			n3_s3  <= c1_s2 * d2y_s2;
			n4_s3  <= c2_s2 * d1y_s2;

			c_s4    <= c_s3;
			nx_s4   <= NW'(n1_s3) - NW'(n2_s3);
			ny_s4   <= NW'(n3_s3) - NW'(n4_s3);
			adet_s4 <= adet_c;
			dneg_s4 <= det_s3[DW-1];
			par_s4  <= (adet_c == '0) ||
				(adet_c < {{(DW-segint_pkg::DET_TOL_W){1'b0}}, det_tol_q});
		end
	end

	// dividers for both axes
	logic [QB-1:0] qx_mag, qy_mag;
	logic          qx_neg, qy_neg, qx_big, qy_big;

	segint_div u_div_x (
		.clk(clk), .ce(ce), .num(nx_s4), .den_mag(adet_s4), .den_neg(dneg_s4),
		.q_mag(qx_mag), .q_neg(qx_neg), .big(qx_big)
	);
	segint_div u_div_y (
		.clk(clk), .ce(ce), .num(ny_s4), .den_mag(adet_s4), .den_neg(dneg_s4),
		.q_mag(qy_mag), .q_neg(qy_neg), .big(qy_big)
	);

	// carry the side data along the divider stages
	segint_pkg::side_t side_s [QB+1];
	always_ff @(posedge clk) begin
		if (ce) begin
			side_s[0] <= '{par_s4, c_s4};
			for (int k = 0; k < QB; k++) side_s[k+1] <= side_s[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			for (int k = 0; k <= QB; k++) vd_s[k] <= 1'b0;
			out_v_q <= 1'b0;
		end else if (ce) begin
			v_s1 <= in_seg.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			vd_s[0] <= v_s4;
			for (int k = 0; k < QB; k++) vd_s[k+1] <= vd_s[k];
			out_v_q <= vd_s[QB];
		end
	end

	// final tests
	function automatic logic in_box(input logic signed [EW-1:0] px,
		input logic signed [EW-1:0] py, input logic signed [W-1:0] ax,
		input logic signed [W-1:0] ay, input logic signed [W-1:0] bx,
		input logic signed [W-1:0] by, input logic signed [EW-1:0] tol);
		logic signed [EW-1:0] lx, hx, ly, hy;
		lx = (ax < bx) ? EW'(ax) : EW'(bx);
		hx = (ax < bx) ? EW'(bx) : EW'(ax);
		ly = (ay < by) ? EW'(ay) : EW'(by);
		hy = (ay < by) ? EW'(by) : EW'(ay);
		return (px >= lx - tol) && (px <= hx + tol) && (py >= ly - tol) && (py <= hy + tol);
	endfunction

	function automatic logic near_pt(input logic signed [EW-1:0] px,
		input logic signed [EW-1:0] py, input logic signed [W-1:0] ex,
		input logic signed [W-1:0] ey, input logic signed [EW-1:0] tol);
		logic signed [EW:0] dx, dy, t;
		dx = (EW+1)'(px) - (EW+1)'(ex);
		dy = (EW+1)'(py) - (EW+1)'(ey);
		t  = (EW+1)'(tol);
		return (dx < t) && (dx > -t) && (dy < t) && (dy > -t);
	endfunction

	function automatic logic signed [W-1:0] sat(input logic signed [EW-1:0] v);
		logic signed [EW-1:0] hi, lo;
		hi = EW'((2 ** (W-1)) - 1);
		lo = -hi - EW'(1);
		return (v > hi) ? W'(hi) : ((v < lo) ? W'(lo) : W'(v));
	endfunction

	segint_pkg::side_t    sd;
	logic signed [EW-1:0] px, py, tol;
	logic                 in_both, near;
	logic [1:0]           st_c;

	assign sd  = side_s[QB];
	assign px  = qx_neg ? -EW'(qx_mag) : EW'(qx_mag);
	assign py  = qy_neg ? -EW'(qy_mag) : EW'(qy_mag);
	assign tol = EW'(coord_tol_q);
	assign in_both = !qx_big && !qy_big &&
		in_box(px, py, sd.c.x1, sd.c.y1, sd.c.x2, sd.c.y2, tol) &&
		in_box(px, py, sd.c.x3, sd.c.y3, sd.c.x4, sd.c.y4, tol);
	assign near = near_pt(px, py, sd.c.x1, sd.c.y1, tol) ||
		near_pt(px, py, sd.c.x2, sd.c.y2, tol) ||
		near_pt(px, py, sd.c.x3, sd.c.y3, tol) ||
		near_pt(px, py, sd.c.x4, sd.c.y4, tol);

	always_comb begin
		if (sd.par) st_c = segint_pkg::ST_PARALLEL;
		else if (!in_both) st_c = segint_pkg::ST_OUTSIDE;
		else if (near) st_c = segint_pkg::ST_ENDPOINT;
		else st_c = segint_pkg::ST_HIT;
	end

	// output register
	logic [1:0]          status_q;
	logic signed [W-1:0] cross_x_q, cross_y_q;
	always_ff @(posedge clk) begin
		if (ce) begin
			status_q  <= st_c;
			cross_x_q <= (st_c == segint_pkg::ST_HIT) ? sat(px) : '0;
			cross_y_q <= (st_c == segint_pkg::ST_HIT) ? sat(py) : '0;
		end
	end

	assign out_res.valid   = out_v_q;
	assign out_res.status  = status_q;
	assign out_res.cross_x = cross_x_q;
	assign out_res.cross_y = cross_y_q;
endmodule
`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none
module testbench;
	localparam int W     = segint_pkg::W;
	localparam int QB    = segint_pkg::QB;
	localparam int CFG_W = segint_pkg::CFG_W;

	localparam int PIPE_LAT   = QB + 6;
	localparam int IDLE_LIMIT = 4000;
	localparam int RAND_ITEMS = 100;

	typedef struct packed {
		logic [1:0]          st;
		logic signed [W-1:0] x;
		logic signed [W-1:0] y;
	} crossing_t;

	typedef enum int {
		PK_NOISE, PK_CROSS, PK_PARALLEL, PK_TOUCH, PK_NEAR_PAR, PK_POINT
	} pair_kind_t;

	typedef struct {
		shortint    c[8];
		bit         fixed;
		logic [1:0] st;
		shortint    x;
		shortint    y;
	} seg_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [CFG_W-1:0] cfg_data;

	segint_in_if  seg_req();
	segint_out_if seg_res();

	segment_intersection i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_seg   (seg_req),
		.out_res  (seg_res)
	);

	// shadow copies of the tolerance registers
	longint det_tol;
	longint coord_tol;

	crossing_t crossings_due[$];
	int  errors;
	int  idle_cycles;
	bit  gaps_on;
	bit  stalls_on;

	seg_row_t dir_rows[] = '{
		'{'{0, 0, 0, 0, 0, 0, 0, 0},           1'b1, segint_pkg::ST_PARALLEL, 0, 0},
		'{'{0, 0, 160, 0, 0, 16, 160, 16},     1'b1, segint_pkg::ST_PARALLEL, 0, 0},
		'{'{0, 0, 320, 320, 0, 320, 320, 0},   1'b1, segint_pkg::ST_HIT, 160, 160},
		'{'{0, 0, 320, 0, 160, 0, 160, 320},   1'b1, segint_pkg::ST_ENDPOINT, 0, 0},
		'{'{0, 0, 16, 16, 320, 0, 336, -16},   1'b1, segint_pkg::ST_OUTSIDE, 0, 0},
		'{'{0, 0, 16, 0, 0, 16, 16, 17},             1'b0, 0, 0, 0},
		'{'{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768},
		                                            1'b0, 0, 0, 0},
		'{'{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767},
		                                      1'b1, segint_pkg::ST_PARALLEL, 0, 0},
		'{'{-32768, 0, 32767, 0, 0, -32768, 0, 32767}, 1'b0, 0, 0, 0},
		'{'{-32768, -32768, -32768, 32767, -32768, 0, 32767, 0},
		                                            1'b0, 0, 0, 0},
		'{'{32767, -32768, 32767, 32767, -32768, 100, 32767, 100},
		                                            1'b0, 0, 0, 0},
		'{'{-1, -1, 1, 1, -1, 1, 1, -1},             1'b0, 0, 0, 0},
		'{'{0, 0, 32, 0, 16, 1, 16, 32},             1'b0, 0, 0, 0},
		'{'{0, 0, 320, 320, 0, 320, 320, 320},       1'b0, 0, 0, 0},
		'{'{-320, 5, 320, -7, 3, -320, -9, 320},     1'b0, 0, 0, 0}
	};

	// clock
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic bit in_box(longint px, longint py, longint xa, longint ya,
			longint xb, longint yb);
		longint lx, hx, ly, hy;
		lx = xa < xb ? xa : xb; hx = xa < xb ? xb : xa;
		ly = ya < yb ? ya : yb; hy = ya < yb ? yb : ya;
		return px >= lx - coord_tol && px <= hx + coord_tol &&
			py >= ly - coord_tol && py <= hy + coord_tol;
	endfunction

	function automatic bit near_end(longint px, longint py, longint ex, longint ey);
		longint dx, dy;
		dx = px - ex; dy = py - ey;
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		return dx < coord_tol && dy < coord_tol;
	endfunction

	function automatic crossing_t predict_crossing(segint_pkg::coords_t c);
		longint x1, y1, x2, y2, x3, y3, x4, y4;
		longint d1x, d1y, d2x, d2y, det, adet, c1, c2, px, py;
		longint lim;
		crossing_t r;
		x1 = c.x1; y1 = c.y1; x2 = c.x2; y2 = c.y2;
		x3 = c.x3; y3 = c.y3; x4 = c.x4; y4 = c.y4;
		lim = 64'sd1 << 40;
		r = '{segint_pkg::ST_PARALLEL, '0, '0};
		d1x = x1 - x2; d1y = y1 - y2; d2x = x3 - x4; d2y = y3 - y4;
		det = d1x * d2y - d1y * d2x;
		adet = det < 0 ? -det : det;
		if (det == 0 || adet < det_tol)
			return r;
		c1 = x1 * y2 - y1 * x2;
		c2 = x3 * y4 - y3 * x4;
		px = (c1 * d2x - c2 * d1x) / det;
		py = (c1 * d2y - c2 * d1y) / det;
		// clamp far quotients well outside any box
		if (px > lim) px = lim;
		if (px < -lim) px = -lim;
		if (py > lim) py = lim;
		if (py < -lim) py = -lim;
		if (!in_box(px, py, x1, y1, x2, y2) || !in_box(px, py, x3, y3, x4, y4)) begin
			r.st = segint_pkg::ST_OUTSIDE;
			return r;
		end
		if (near_end(px, py, x1, y1) || near_end(px, py, x2, y2) ||
				near_end(px, py, x3, y3) || near_end(px, py, x4, y4)) begin
			r.st = segint_pkg::ST_ENDPOINT;
			return r;
		end
		r.st = segint_pkg::ST_HIT;
		r.x  = px > 32767 ? 16'sd32767 : (px < -32768 ? -16'sd32768 : W'(px));
		r.y  = py > 32767 ? 16'sd32767 : (py < -32768 ? -16'sd32768 : W'(py));
		return r;
	endfunction

	function automatic logic signed [W-1:0] clip(int v);
		if (v > 32767) return 16'sd32767;
		if (v < -32768) return -16'sd32768;
		return W'(v);
	endfunction

	function automatic int pick(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// random segment pair, mostly shaped to reach the crossing tests
	function automatic segint_pkg::coords_t random_pair();
		segint_pkg::coords_t c;
		pair_kind_t kind;
		int span, ax1, ay1, ax2, ay2, bx1, by1, px, py, k, ox, oy;
		c = {$urandom, $urandom, $urandom, $urandom};
		case ($urandom_range(0, 9))
			0, 1:    kind = PK_NOISE;
			6:       kind = PK_PARALLEL;
			7:       kind = PK_TOUCH;
			8:       kind = PK_NEAR_PAR;
			9:       kind = PK_POINT;
			default: kind = PK_CROSS;
		endcase
		case ($urandom_range(0, 3))
			0:       span = 32767;
			1:       span = 4000;
			default: span = 300;
		endcase
		ax1 = pick(span); ay1 = pick(span); ax2 = pick(span); ay2 = pick(span);
		bx1 = pick(span); by1 = pick(span);
		ox = pick(64); oy = pick(64);
		c.x1 = clip(ax1); c.y1 = clip(ay1); c.x2 = clip(ax2); c.y2 = clip(ay2);
		case (kind)
			PK_CROSS: begin
				k  = $urandom_range(0, 16);
				px = ax1 + (ax2 - ax1) * k / 16;
				py = ay1 + (ay2 - ay1) * k / 16;
				c.x3 = clip(bx1); c.y3 = clip(by1);
				c.x4 = clip(2 * px - bx1); c.y4 = clip(2 * py - by1);
			end
			PK_PARALLEL: begin
				c.x3 = clip(ax1 + ox); c.y3 = clip(ay1 + oy);
				c.x4 = clip(ax2 + ox); c.y4 = clip(ay2 + oy);
			end
			PK_NEAR_PAR: begin
				c.x3 = clip(ax1 + ox); c.y3 = clip(ay1 + oy);
				c.x4 = clip(ax2 + ox + pick(1)); c.y4 = clip(ay2 + oy + pick(1));
			end
			PK_TOUCH: begin
				c.x3 = $urandom_range(0, 1) ? c.x2 : c.x1;
				c.y3 = c.x3 == c.x2 ? c.y2 : c.y1;
				c.x4 = clip(bx1); c.y4 = clip(by1);
			end
			PK_POINT: begin
				c.x2 = c.x1; c.y2 = c.y1;
			end
			default: ;
		endcase
		return c;
	endfunction

	task automatic write_reg(logic idx, int value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == segint_pkg::REG_DET_TOL)
			det_tol = value & 16'hFFFF;
		else
			coord_tol = value & 8'hFF;
	endtask

	// hold the request until accepted, then queue its fixed or predicted crossing
	task automatic send_pair(segint_pkg::coords_t c, bit fixed, crossing_t fixed_res);
		int gap;
		gap = gaps_on ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			seg_req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		seg_req.valid     <= 1'b1;
		seg_req.a_start_x <= c.x1;
		seg_req.a_start_y <= c.y1;
		seg_req.a_end_x   <= c.x2;
		seg_req.a_end_y   <= c.y2;
		seg_req.b_start_x <= c.x3;
		seg_req.b_start_y <= c.y3;
		seg_req.b_end_x   <= c.x4;
		seg_req.b_end_y   <= c.y4;
		do @(posedge clk); while (!seg_req.ready);
		crossings_due.insert(crossings_due.size(), fixed ? fixed_res : predict_crossing(c));
	endtask

	task automatic drain();
		seg_req.valid <= 1'b0;
		while (crossings_due.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 6) @(posedge clk);
	endtask

	task automatic random_phase(int dt, int ct);
		write_reg(segint_pkg::REG_DET_TOL, dt);
		write_reg(segint_pkg::REG_COORD_TOL, ct);
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 25 == 0) begin
				gaps_on   = $urandom_range(0, 3) != 0;
				stalls_on = $urandom_range(0, 3) != 0;
			end
			send_pair(random_pair(), 1'b0, '0);
		end
		drain();
	endtask

	// result side: stall at random, compare each result with the oldest queued crossing
	initial begin
		int stall;
		crossing_t want;
		seg_res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = stalls_on ? $urandom_range(0, 14) : 0;
			if (stall > 0) begin
				seg_res.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			seg_res.ready <= 1'b1;
			do @(posedge clk); while (!seg_res.valid);
			if (crossings_due.size() == 0) begin
				$display("%0t: unexpected result status=%0d x=%0d y=%0d", $time,
					seg_res.status, seg_res.cross_x, seg_res.cross_y);
				errors++;
			end else begin
				want = crossings_due.pop_front();
				if (seg_res.status !== want.st) begin
					$display("%0t: status expected %0d got %0d", $time, want.st,
						seg_res.status);
					errors++;
				end
				if (seg_res.cross_x !== want.x) begin
					$display("%0t: cross_x expected %0d got %0d", $time, want.x,
						seg_res.cross_x);
					errors++;
				end
				if (seg_res.cross_y !== want.y) begin
					$display("%0t: cross_y expected %0d got %0d", $time, want.y,
						seg_res.cross_y);
					errors++;
				end
			end
		end
	end

	// watchdog: count cycles with no request moving on either side
	always @(posedge clk) begin
		if ((seg_req.valid && seg_req.ready) || (seg_res.valid && seg_res.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// stimulus
	initial begin
		segint_pkg::coords_t c;
		crossing_t res;
		errors = 0;
		idle_cycles = 0;
		det_tol = 1;
		coord_tol = 1;
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		seg_req.valid = 1'b0;
		{seg_req.a_start_x, seg_req.a_start_y, seg_req.a_end_x, seg_req.a_end_y} = '0;
		{seg_req.b_start_x, seg_req.b_start_y, seg_req.b_end_x, seg_req.b_end_y} = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows at reset tolerances
		foreach (dir_rows[i]) begin
			c = {dir_rows[i].c[0], dir_rows[i].c[1], dir_rows[i].c[2], dir_rows[i].c[3],
				dir_rows[i].c[4], dir_rows[i].c[5], dir_rows[i].c[6], dir_rows[i].c[7]};
			res = '{dir_rows[i].st, dir_rows[i].x, dir_rows[i].y};
			send_pair(c, dir_rows[i].fixed, res);
		end
		drain();

		random_phase(1, 1);
		random_phase(0, 0);
		random_phase(65535, 255);
		random_phase(0, 255);
		random_phase(65535, 0);
		random_phase($urandom_range(0, 65535), $urandom_range(0, 255));
		random_phase($urandom_range(0, 4096), $urandom_range(0, 16));

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
`default_nettype wire
